@@ hdl/seglcd_pkg.sv @@
package seglcd_pkg;

  // Segment bits held per common line, and the fixed width of a reported row
  localparam int unsigned SegmentsPerCommon = 24;
  localparam int unsigned RowOutW           = 24;
  localparam int unsigned DigitCount        = 10;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

  // Glyph table spans the printable range
  localparam logic [6:0] GlyphBase  = 7'h20;
  localparam int unsigned GlyphCount = 95;
  localparam logic [5:0] SegFieldMask = 6'h3F;

  typedef enum logic [1:0] {
    CMD_WRITE_CHAR = 2'd0,
    CMD_SET_SEG    = 2'd1,
    CMD_CLR_SEG    = 2'd2,
    CMD_CLR_ALL    = 2'd3
  } cmd_e;

  // Extra segment lit after the glyph has been drawn
  typedef enum logic [1:0] {
    FIX_NONE     = 2'd0,
    FIX_SET_0_15 = 2'd1,
    FIX_SET_1_12 = 2'd2,
    FIX_SET_0_12 = 2'd3
  } fix_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] glyph;
    logic [3:0] pos;
    logic       pos_ok;
    logic       pre_clr;
    fix_e       fix;
    logic [1:0] com;
    logic [4:0] seg;
  } job_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [QCountW-1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic idle;
    logic finish;
  } back_stat_t;

  localparam logic [7:0] GlyphTable [GlyphCount] = '{
    8'h00, 8'h60, 8'h22, 8'h63, 8'h00, 8'h00, 8'h44, 8'h20,
    8'h39, 8'h0F, 8'h00, 8'hC0, 8'h04, 8'h40, 8'h40, 8'h12,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h58, 8'h48, 8'h4C, 8'h53,
    8'hFF, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h89, 8'h0E, 8'h75, 8'h38, 8'hB7, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'hF7, 8'h6D, 8'h81, 8'h3E, 8'h3E, 8'hBE,
    8'h7E, 8'h6E, 8'h1B, 8'h39, 8'h24, 8'h0F, 8'h23, 8'h08,
    8'h02, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h10, 8'h42, 8'h75, 8'h30, 8'hB7, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h62, 8'h1C, 8'hBE,
    8'h7E, 8'h6E, 8'h1B, 8'h39, 8'h30, 8'h0F, 8'h01
  };

  // One byte per glyph bit, lowest byte first: common in [7:6], segment in [5:0]
  localparam logic [63:0] SegMap [DigitCount] = '{
    64'h4e4f0e8e8f8d4d0d,
    64'h0c8c4c4c8b4b4b0b,
    64'hc049c00a49890949,
    64'hc048088886874707,
    64'hc053921252139352,
    64'hc054511415559594,
    64'hc057965616179716,
    64'hc041804000018a81,
    64'hc043420203048382,
    64'hc045440506468584
  };

  function automatic logic [7:0] glyph_lookup(input logic [6:0] ch);
    logic [6:0] idx;
    idx = ch - GlyphBase;
    if (ch >= GlyphBase && ch != 7'h7F) begin
      return GlyphTable[idx];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] seg_map_byte(input logic [3:0] pos, input logic [2:0] step);
    logic [63:0] map;
    map = SegMap[pos];
    return map[{step, 3'b000} +: 8];
  endfunction

endpackage

@@ hdl/seglcd_front.sv @@
module seglcd_front (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [23:0]        s_axis_tdata_i,  // char_code, digit_position, common_line,
                                              // segment_line, zero pad
  input  logic [1:0]         s_axis_tuser_i,  // command
  input  seglcd_pkg::queue_stat_t q_stat_i,
  output logic               push_o,
  output seglcd_pkg::job_t   job_o
);

  // Position-specific character substitutions, applied in order
  function automatic logic [7:0] substitute(input logic [7:0] c, input logic [3:0] pos);
    logic [7:0] ch;
    ch = c;
    if (pos == 4'd4 || pos == 4'd6) begin
      if (ch == "7") ch = "&";
      else if (ch == "A") ch = "a";
      else if (ch == "o") ch = "O";
      else if (ch == "L") ch = "!";
      else if (ch == "M" || ch == "m" || ch == "N") ch = "n";
      else if (ch == "c") ch = "C";
      else if (ch == "J") ch = "j";
      else if (ch == "v" || ch == "V" || ch == "U" || ch == "W" || ch == "w") ch = "u";
    end else begin
      if (ch == "u") ch = "v";
      else if (ch == "j") ch = "J";
    end
    if (pos > 4'd1 && ch == "T") ch = "t";
    if (pos == 4'd1) begin
      if (ch == "o") ch = "O";
      if (ch == "i") ch = "l";
      if (ch == "n") ch = "N";
      if (ch == "r") ch = "R";
      if (ch == "d") ch = "D";
      if (ch == "v" || ch == "V" || ch == "u") ch = "U";
      if (ch == "b") ch = "B";
      if (ch == "c") ch = "C";
    end else begin
      if (ch == "R") ch = "r";
    end
    if (pos != 4'd0 && ch == "I") ch = "l";
    return ch;
  endfunction

  logic [3:0] pos;
  logic [7:0] ch;

  assign pos = s_axis_tdata_i[10:7];
  assign ch  = substitute({1'b0, s_axis_tdata_i[6:0]}, pos);

  assign s_axis_tready_o = !q_stat_i.full;
  assign push_o          = s_axis_tvalid_i && !q_stat_i.full;

  always_comb begin
    job_o.cmd     = seglcd_pkg::cmd_e'(s_axis_tuser_i);
    job_o.glyph   = seglcd_pkg::glyph_lookup(ch[6:0]);
    job_o.pos     = pos;
    job_o.pos_ok  = pos < 4'(seglcd_pkg::DigitCount);
    job_o.pre_clr = pos == 4'd0;
    job_o.com     = s_axis_tdata_i[12:11];
    job_o.seg     = s_axis_tdata_i[17:13];
    if (ch == "T" && pos == 4'd1) begin
      job_o.fix = seglcd_pkg::FIX_SET_1_12;
    end else if (pos == 4'd0 && (ch == "B" || ch == "D")) begin
      job_o.fix = seglcd_pkg::FIX_SET_0_15;
    end else if (pos == 4'd1 && (ch == "B" || ch == "D" || ch == "@")) begin
      job_o.fix = seglcd_pkg::FIX_SET_0_12;
    end else begin
      job_o.fix = seglcd_pkg::FIX_NONE;
    end
  end

endmodule

@@ hdl/seglcd_queue.sv @@
module seglcd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  seglcd_pkg::job_t        job_i,
  input  logic                    pop_i,
  output seglcd_pkg::job_t        job_o,
  output seglcd_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(seglcd_pkg::QueueDepth);

  seglcd_pkg::job_t entry_q [seglcd_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [seglcd_pkg::QCountW-1:0] count_q;
  logic do_push, do_pop;

  assign stat_o.full  = count_q == seglcd_pkg::QCountW'(seglcd_pkg::QueueDepth);
  assign stat_o.empty = count_q == '0;
  assign stat_o.count = count_q;
  assign job_o        = entry_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + seglcd_pkg::QCountW'(1);
        2'b01:   count_q <= count_q - seglcd_pkg::QCountW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

endmodule

@@ hdl/seglcd_back.sv @@
module seglcd_back #(
  parameter int unsigned SEGMENTS_PER_COMMON = seglcd_pkg::SegmentsPerCommon
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  seglcd_pkg::job_t       job_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [3*seglcd_pkg::RowOutW-1:0] m_axis_tdata_o,  // row_zero, row_one, row_two
  output seglcd_pkg::back_stat_t stat_o
);

  localparam int unsigned SegIdxW = $clog2(SEGMENTS_PER_COMMON);
  localparam int unsigned RowW    = seglcd_pkg::RowOutW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIXUP,
    ST_FINISH
  } state_e;

  typedef logic [SEGMENTS_PER_COMMON-1:0] row_t;

  state_e             state_q;
  logic [2:0]         step_q;
  seglcd_pkg::job_t   job_q;
  row_t               mem_q [3];
  row_t               mem_d [3];
  logic [3*RowW-1:0]  out_q;
  logic               out_valid_q;

  logic       wr_en, wr_val, clr_all;
  logic [1:0] wr_com;
  logic [5:0] wr_seg;
  logic [7:0] entry;
  logic       out_free;

  assign entry    = seglcd_pkg::seg_map_byte(job_q.pos, step_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = state_q == ST_IDLE && job_valid_i;

  assign stat_o.idle   = state_q == ST_IDLE;
  assign stat_o.finish = state_q == ST_FINISH;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // One segment write per cycle, or a clear of every row at once
  always_comb begin
    wr_en   = 1'b0;
    wr_val  = 1'b0;
    wr_com  = 2'd0;
    wr_seg  = 6'd0;
    clr_all = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          case (job_i.cmd)
            seglcd_pkg::CMD_WRITE_CHAR: begin
              wr_en  = job_i.pos_ok && job_i.pre_clr;
              wr_seg = 6'd15;
            end
            seglcd_pkg::CMD_SET_SEG: begin
              wr_en  = 1'b1;
              wr_val = 1'b1;
              wr_com = job_i.com;
              wr_seg = {1'b0, job_i.seg};
            end
            seglcd_pkg::CMD_CLR_SEG: begin
              wr_en  = 1'b1;
              wr_com = job_i.com;
              wr_seg = {1'b0, job_i.seg};
            end
            default: clr_all = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        wr_en  = 1'b1;
        wr_val = job_q.glyph[step_q];
        wr_com = entry[7:6];
        wr_seg = entry[5:0] & seglcd_pkg::SegFieldMask;
      end
      ST_FIXUP: begin
        wr_val = 1'b1;
        case (job_q.fix)
          seglcd_pkg::FIX_SET_0_15: begin
            wr_en  = 1'b1;
            wr_seg = 6'd15;
          end
          seglcd_pkg::FIX_SET_1_12: begin
            wr_en  = 1'b1;
            wr_com = 2'd1;
            wr_seg = 6'd12;
          end
          seglcd_pkg::FIX_SET_0_12: begin
            wr_en  = 1'b1;
            wr_seg = 6'd12;
          end
          default: wr_en = 1'b0;
        endcase
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Apply the write or the clear of all rows; skip common 3 and segments beyond the row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mem_d[r] = mem_q[r];
    end
    if (clr_all) begin
      for (int r = 0; r < 3; r++) begin
        mem_d[r] = '0;
      end
    end else if (wr_en && wr_com != 2'd3 &&
                 {1'b0, wr_seg} < 7'(SEGMENTS_PER_COMMON)) begin
      mem_d[wr_com][wr_seg[SegIdxW-1:0]] = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 3'd0;
      job_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        mem_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        mem_q[r] <= mem_d[r];
      end
      // Drop a taken beat; the finish step reloads the register itself
      if (state_q != ST_FINISH && out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            step_q <= 3'd0;
            if (job_i.cmd == seglcd_pkg::CMD_WRITE_CHAR && job_i.pos_ok) begin
              state_q <= ST_WALK;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_WALK: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) state_q <= ST_FIXUP;
        end
        ST_FIXUP: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            out_q       <= {mem_q[2][RowW-1:0], mem_q[1][RowW-1:0], mem_q[0][RowW-1:0]};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/segment_lcd_character_writer_core.sv @@
// Channel   Dir  Beat fields (tdata from bit 0 up)                      Width
// s_axis    in   tuser: command; tdata: char_code, digit_position,      2 + 24
//                common_line, segment_line, zero pad
// m_axis    out  tdata: row_zero, row_one, row_two                      72
//
// A character write runs the back sequencer: idle takes the command, walk
// reads the position's segment map one byte a cycle, fixup sets the trailing
// extra segment, finish loads the result register once m_axis is free. Set,
// clear and clear-all go from idle to finish. Reset clears the display memory
// at once, with no sweep. The two-entry command queue keeps s_axis ready while
// the back end works or a result beat waits on m_axis; only a full queue drops tready.
module segment_lcd_character_writer_core #(
  parameter int unsigned SEGMENTS_PER_COMMON = seglcd_pkg::SegmentsPerCommon
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // char_code[6:0], digit_position[10:7],
                                        // common_line[12:11], segment_line[17:13], pad
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // row_zero[23:0], row_one[47:24], row_two[71:48]
);

  seglcd_pkg::job_t        push_job, head_job;
  seglcd_pkg::queue_stat_t q_stat;
  seglcd_pkg::back_stat_t  back_stat;
  logic                    q_push, q_pop;

  // Front: classify the beat, substitute and look up the glyph
  seglcd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_stat_i        (q_stat),
    .push_o          (q_push),
    .job_o           (push_job)
  );

  // Queue: decouple the front from the sequencer
  seglcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  // Back: walk the segment map and hold the display memory
  seglcd_back #(
    .SEGMENTS_PER_COMMON (SEGMENTS_PER_COMMON)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!q_stat.empty),
    .job_i           (head_job),
    .pop_o           (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .stat_o          (back_stat)
  );

  // Take a queued command only when the sequencer is idle
  a_pop_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> back_stat.idle && !q_stat.empty)
    else $error("command taken while sequencer busy");

  // Hold occupancy within the queue depth
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= seglcd_pkg::QCountW'(seglcd_pkg::QueueDepth))
    else $error("queue occupancy beyond depth");

  // A result beat appears only out of the finish step
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(back_stat.finish))
    else $error("result beat without finish step");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SEG_W = seglcd_pkg::SegmentsPerCommon;

  // One display frame as carried on m_axis: row_zero in the lowest bits
  typedef struct packed {
    logic [23:0] row_two;
    logic [23:0] row_one;
    logic [23:0] row_zero;
  } lcd_frame_t;

  localparam logic [7:0] CHAR_FONT [95] = '{
    8'h00, 8'h60, 8'h22, 8'h63, 8'h00, 8'h00, 8'h44, 8'h20,
    8'h39, 8'h0F, 8'h00, 8'hC0, 8'h04, 8'h40, 8'h40, 8'h12,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h58, 8'h48, 8'h4C, 8'h53,
    8'hFF, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h89, 8'h0E, 8'h75, 8'h38, 8'hB7, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'hF7, 8'h6D, 8'h81, 8'h3E, 8'h3E, 8'hBE,
    8'h7E, 8'h6E, 8'h1B, 8'h39, 8'h24, 8'h0F, 8'h23, 8'h08,
    8'h02, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h10, 8'h42, 8'h75, 8'h30, 8'hB7, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h62, 8'h1C, 8'hBE,
    8'h7E, 8'h6E, 8'h1B, 8'h39, 8'h30, 8'h0F, 8'h01
  };

  // Per digit: eight (common, segment) bytes, glyph bit 0 in the lowest byte
  localparam logic [63:0] DIGIT_WIRING [10] = '{
    64'h4e4f0e8e8f8d4d0d,
    64'h0c8c4c4c8b4b4b0b,
    64'hc049c00a49890949,
    64'hc048088886874707,
    64'hc053921252139352,
    64'hc054511415559594,
    64'hc057965616179716,
    64'hc041804000018a81,
    64'hc043420203048382,
    64'hc045440506468584
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = seglcd_pkg::CMD_CLR_ALL;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  // Predicted display memory and frames still owed by the block
  logic [SEG_W-1:0] lcd_rows [3];
  lcd_frame_t       frames_due [$];

  int  mismatch_count = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  rx_hold_cycles = 0;

  string tricky_chars = "7AoLMmNcJvVUWwujTtRrioInNdDbBcCTI@";

  segment_lcd_character_writer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Display memory predictor
  // ---------------------------------------------------------------------------

  function automatic void place_seg(logic [1:0] com, logic [5:0] seg, bit on);
    if (com > 2'd2 || seg >= SEG_W) begin
      return;
    end
    lcd_rows[com][seg] = on;
  endfunction

  // Position-dependent letter swaps, applied in this order
  function automatic logic [7:0] remap_char(logic [7:0] ch, logic [3:0] pos);
    logic [7:0] c;
    c = ch;
    if (pos == 4'd4 || pos == 4'd6) begin
      case (c)
        "7":                     c = "&";
        "A":                     c = "a";
        "o":                     c = "O";
        "L":                     c = "!";
        "M", "m", "N":           c = "n";
        "c":                     c = "C";
        "J":                     c = "j";
        "v", "V", "U", "W", "w": c = "u";
        default: ;
      endcase
    end else begin
      if (c == "u") c = "v";
      else if (c == "j") c = "J";
    end
    if (pos > 4'd1 && c == "T") c = "t";
    if (pos == 4'd1) begin
      if (c == "o") c = "O";
      if (c == "i") c = "l";
      if (c == "n") c = "N";
      if (c == "r") c = "R";
      if (c == "d") c = "D";
      if (c == "v" || c == "V" || c == "u") c = "U";
      if (c == "b") c = "B";
      if (c == "c") c = "C";
    end else if (c == "R") begin
      c = "r";
    end
    if (pos != 4'd0 && c == "I") c = "l";
    return c;
  endfunction

  function automatic void draw_char(logic [6:0] ch, logic [3:0] pos);
    logic [7:0]  c;
    logic [7:0]  bits;
    logic [63:0] wiring;
    logic [7:0]  entry;
    if (pos >= seglcd_pkg::DigitCount) begin
      return;
    end
    c = remap_char({1'b0, ch}, pos);
    // Digit 0 shares its top-left segment with an annunciator: drop it first
    if (pos == 4'd0) place_seg(2'd0, 6'd15, 1'b0);
    bits = (c >= 8'h20 && c < 8'h7F) ? CHAR_FONT[c - 8'h20] : 8'h00;
    wiring = DIGIT_WIRING[pos];
    for (int i = 0; i < 8; i++) begin
      entry = wiring[8*i +: 8];
      if (entry[7:6] != 2'd3) begin
        place_seg(entry[7:6], entry[5:0], 1'b0);
        if (bits[i]) place_seg(entry[7:6], entry[5:0], 1'b1);
      end
    end
    // Extra segment lit after the glyph: descender, ninth segment, digit 0 bar
    if (c == "T" && pos == 4'd1) place_seg(2'd1, 6'd12, 1'b1);
    else if (pos == 4'd0 && (c == "B" || c == "D")) place_seg(2'd0, 6'd15, 1'b1);
    else if (pos == 4'd1 && (c == "B" || c == "D" || c == "@")) place_seg(2'd0, 6'd12, 1'b1);
  endfunction

  function automatic lcd_frame_t apply_command(seglcd_pkg::cmd_e cmd, logic [6:0] ch,
                                               logic [3:0] pos, logic [1:0] com,
                                               logic [4:0] seg);
    lcd_frame_t f;
    case (cmd)
      seglcd_pkg::CMD_WRITE_CHAR: draw_char(ch, pos);
      seglcd_pkg::CMD_SET_SEG:    place_seg(com, {1'b0, seg}, 1'b1);
      seglcd_pkg::CMD_CLR_SEG:    place_seg(com, {1'b0, seg}, 1'b0);
      default: begin
        for (int r = 0; r < 3; r++) lcd_rows[r] = '0;
      end
    endcase
    f.row_zero = lcd_rows[0][23:0];
    f.row_one  = lcd_rows[1][23:0];
    f.row_two  = lcd_rows[2][23:0];
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Command sender: call at a rising edge, returns at a rising edge
  // ---------------------------------------------------------------------------

  task automatic send_cmd(seglcd_pkg::cmd_e cmd, logic [6:0] ch, logic [3:0] pos,
                          logic [1:0] com, logic [4:0] seg);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, seg, com, pos, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_due.push_back(apply_command(cmd, ch, pos, com, seg));
    // Random gap after the beat; valid stays high when none is taken
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Mostly meaningful commands; unused fields carry random junk throughout
  task automatic send_random_cmd();
    int               pick;
    int               k;
    seglcd_pkg::cmd_e cmd;
    logic [6:0]       ch;
    logic [3:0]       pos;
    logic [1:0]       com;
    logic [4:0]       seg;
    ch   = 7'($urandom);
    pos  = 4'($urandom);
    com  = 2'($urandom);
    seg  = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      cmd = seglcd_pkg::CMD_WRITE_CHAR;
      pos = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      k = $urandom_range(0, 9);
      if (k < 4) ch = 7'(tricky_chars[$urandom_range(0, tricky_chars.len() - 1)]);
      else if (k < 9) ch = 7'($urandom_range(32, 126));
      else ch = 7'($urandom_range(0, 127));
    end else begin
      if (pick < 80) cmd = seglcd_pkg::CMD_SET_SEG;
      else if (pick < 98) cmd = seglcd_pkg::CMD_CLR_SEG;
      else cmd = seglcd_pkg::CMD_CLR_ALL;
      com = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      seg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                        : 5'($urandom_range(0, 23));
    end
    send_cmd(cmd, ch, pos, com, seg);
  endtask

  task automatic wait_frames_drained();
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, logic [23:0] want, logic [23:0] got);
    if (mismatch_count < 10)
      $display("%0t: %s expected %06h got %06h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    lcd_frame_t want;
    lcd_frame_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (frames_due.size() == 0) begin
        note_mismatch("unexpected beat row_zero", 24'd0, got.row_zero);
      end else begin
        want = frames_due.pop_front();
        if (got.row_zero != want.row_zero) note_mismatch("row_zero", want.row_zero, got.row_zero);
        if (got.row_one  != want.row_one)  note_mismatch("row_one",  want.row_one,  got.row_one);
        if (got.row_two  != want.row_two)  note_mismatch("row_two",  want.row_two,  got.row_two);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stall bursts
  initial begin : rx_ready_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_cmd(seglcd_pkg::CMD_CLR_ALL, 7'h7F, 4'd15, 2'd3, 5'd31);
    // Full glyph at every digit walks every wiring byte, common 3 included
    for (int p = 0; p < 10; p++) send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'h40, 4'(p), 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'(8'("B")), 4'd0, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'(8'("D")), 4'd1, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'(8'("T")), 4'd1, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'h00, 4'd2, 2'd3, 5'd31);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'h7F, 4'd3, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'h1F, 4'd0, 2'd0, 5'd0);
    // Positions past the last digit leave the memory alone
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'(8'("8")), 4'd10, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_WRITE_CHAR, 7'(8'("8")), 4'd15, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_SET_SEG, 7'd0, 4'd0, 2'd2, 5'd23);
    send_cmd(seglcd_pkg::CMD_SET_SEG, 7'h7F, 4'd15, 2'd0, 5'd0);
    send_cmd(seglcd_pkg::CMD_SET_SEG, 7'd0, 4'd0, 2'd3, 5'd5);
    send_cmd(seglcd_pkg::CMD_SET_SEG, 7'd0, 4'd0, 2'd1, 5'd31);
    send_cmd(seglcd_pkg::CMD_CLR_SEG, 7'd0, 4'd0, 2'd2, 5'd23);
    send_cmd(seglcd_pkg::CMD_CLR_SEG, 7'd0, 4'd0, 2'd3, 5'd13);
    send_cmd(seglcd_pkg::CMD_CLR_SEG, 7'd0, 4'd0, 2'd0, 5'd24);
    send_cmd(seglcd_pkg::CMD_CLR_ALL, 7'd0, 4'd0, 2'd0, 5'd0);
  endtask

  // Hold m_axis off for a long stretch while commands keep coming
  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = tx_idle;
    tx_idle = 1'b0;
    rx_hold_cycles = 300;
    repeat (16) send_random_cmd();
    tx_idle = saved_idle;
  endtask

  task automatic test_drain_pause();
    repeat (25) send_random_cmd();
    wait_frames_drained();
    repeat (25) send_random_cmd();
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random_cmd();
  endtask

  task automatic test_full_rate(int count);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (count) send_random_cmd();
  endtask

  initial begin
    for (int r = 0; r < 3; r++) lcd_rows[r] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_mix(1460);
    test_full_rate(300);

    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < 20000 && frames_due.size() != 0; n++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ segment_lcd_character_writer_core.f @@
hdl/seglcd_pkg.sv
hdl/seglcd_front.sv
hdl/seglcd_queue.sv
hdl/seglcd_back.sv
hdl/segment_lcd_character_writer_core.sv
tb/testbench.sv
